[rtl/core/bitmap_run_allocator_core_macros.svh]
// Assertion helpers for the checker of this block.
`ifndef BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH

// Checked at every clock edge outside reset.
`define BRA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/bra_pkg.sv]
package bra_pkg;

  localparam int CHUNK_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF    = 64;

  localparam int TYPE_W   = 2;
  localparam int START_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 13;

  typedef logic [TYPE_W-1:0]   req_type_t;
  typedef logic [START_W-1:0]  start_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [FREE_W-1:0]   free_t;

  localparam req_type_t REQ_ALLOC = 2'd0;
  localparam req_type_t REQ_FREE  = 2'd1;
  localparam req_type_t REQ_MARK  = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOSPACE = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

endpackage

[rtl/core/bra_if.sv]
interface bra_req_if
  import bra_pkg::*;
();
  logic      valid;
  logic      ready;
  req_type_t req_type;
  start_t    block_start;
  count_t    block_count;

  modport source (output valid, output req_type, output block_start, output block_count,
                  input ready);
  modport sink (input valid, input req_type, input block_start, input block_count,
                output ready);
endinterface

interface bra_rsp_if
  import bra_pkg::*;
();
  logic    valid;
  logic    ready;
  status_t status;
  start_t  alloc_start;
  free_t   free_blocks;

  modport source (output valid, output status, output alloc_start, output free_blocks,
                  input ready);
  modport sink (input valid, input status, input alloc_start, input free_blocks,
                output ready);
endinterface

[rtl/core/bitmap_run_allocator_core.sv]
// Next-fit run allocator over a one-bit-per-block occupancy bitmap held in a
// WORD_BITS-wide RAM. After reset the block clears the bitmap one word a
// cycle with ready low. A request is then served one at a time: ready drops
// on accept and rises again once the result is loaded into the output
// register. Rejected requests go straight to the response state. Otherwise
// the run length (and, for free or mark, the start) is first split into word
// and bit offset by shift and mask.
// Each run check then takes a setup step plus a read and a compare for each
// bitmap word touched, the read of the first word skipped when it is already
// loaded; an allocate repeats this per candidate start, stepping by the run
// length. The update pass reads and then writes each word, then finishes
// through S_FIN and S_RESP. The bitmap RAM has a separate read and write
// port; each further word or candidate start lengthens a request.
module bitmap_run_allocator_core
  import bra_pkg::*;
#(
  parameter int CHUNK_BLOCKS = CHUNK_BLOCKS_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  bra_req_if.sink   req,
  bra_rsp_if.source rsp
);

  localparam int NUM_WORDS = (CHUNK_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(CHUNK_BLOCKS + 1);
  localparam int LW        = BW + 1;
  localparam int WW        = $clog2(2 * NUM_WORDS + 2);
  localparam int OW        = $clog2(WORD_BITS);
  localparam int OS        = OW + 1;
  localparam int CW        = ((BW > COUNT_W) ? BW : COUNT_W) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV_S, S_DIV_N, S_SETUP, S_RD, S_CHK, S_WR_RD, S_WR, S_FIN, S_RESP
  } state_t;

  state_t          state;
  req_type_t       rtype;
  logic            set_run;
  logic [BW-1:0]   n_lin;
  logic [WW-1:0]   n_w;
  logic [OW-1:0]   n_o;
  logic [LW-1:0]   b_lin;
  logic [WW-1:0]   b_w;
  logic [OW-1:0]   b_o;
  logic [LW-1:0]   e_lin;
  logic [WW-1:0]   e_w;
  logic [OW-1:0]   e_o;
  logic [WW-1:0]   last_w;
  logic [OS-1:0]   last_hi;
  logic [WW-1:0]   cur_w;
  logic [WW-1:0]   loaded_w;
  logic            loaded_ok;
  logic [BW-1:0]   free_count;
  logic [BW-1:0]   hint_lin;
  logic [WW-1:0]   hint_w;
  logic [OW-1:0]   hint_o;
  status_t         res_status;
  start_t          res_astart;
  logic [AW-1:0]   clr_idx;
  logic            div_go;
  logic [BW-1:0]   div_arg;
  logic            rsp_valid;
  status_t         rsp_status;
  start_t          rsp_astart;
  free_t           rsp_free;

  logic            div_done;
  logic [BW-1:0]   div_quot;
  logic [OW-1:0]   div_rem;

  logic            accept;
  logic [CW-1:0]   n_c;
  logic [CW-1:0]   s_c;
  logic            is_alloc;
  logic            bad_type;
  logic            bad_len;
  logic            no_room;

  logic [OS-1:0]   o_sum;
  logic            o_wrap;
  logic [OW-1:0]   e_o_c;
  logic [WW-1:0]   e_w_c;
  logic [LW-1:0]   e_lin_c;

  logic [OW-1:0]   lo;
  logic [OS-1:0]   hi;
  logic            run_ok;
  logic [WORD_BITS-1:0] data_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.alloc_start = rsp_astart;
  assign rsp.free_blocks = rsp_free;

  assign accept   = req.valid && req.ready;
  assign n_c      = CW'(req.block_count);
  assign s_c      = CW'(req.block_start);
  assign is_alloc = (req.req_type == REQ_ALLOC);
  assign bad_type = (req.req_type != REQ_ALLOC) && (req.req_type != REQ_FREE) &&
                    (req.req_type != REQ_MARK);
  assign bad_len  = (n_c == '0) ||
                    (is_alloc && (n_c > CW'(CHUNK_BLOCKS))) ||
                    (!is_alloc && ((s_c + n_c) > CW'(CHUNK_BLOCKS)));
  assign no_room  = is_alloc && (n_c > CW'(free_count));

  assign o_sum   = OS'(b_o) + OS'(n_o);
  assign o_wrap  = (o_sum >= OS'(WORD_BITS));
  assign e_o_c   = o_wrap ? OW'(o_sum - OS'(WORD_BITS)) : OW'(o_sum);
  assign e_w_c   = b_w + n_w + WW'(o_wrap);
  assign e_lin_c = b_lin + LW'(n_lin);

  assign lo = (cur_w == b_w) ? b_o : '0;
  assign hi = (cur_w == last_w) ? last_hi : OS'(WORD_BITS);

  assign ram_we    = (state == S_CLEAR) || (state == S_WR);
  assign ram_waddr = (state == S_CLEAR) ? clr_idx : cur_w[AW-1:0];
  assign ram_wdata = (state == S_CLEAR) ? '0 : data_next;
  assign ram_re    = (state == S_RD) || (state == S_WR_RD);

  bra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_bra_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  bra_div #(
    .DW      (BW),
    .DIVISOR (WORD_BITS),
    .RW      (OW)
  ) u_bra_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_arg),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  bra_mask #(
    .WORD_BITS (WORD_BITS),
    .OW        (OW)
  ) u_bra_mask (
    .data      (ram_rdata),
    .lo        (lo),
    .hi        (hi),
    .set_run   (set_run),
    .run_ok    (run_ok),
    .data_next (data_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      free_count <= BW'(CHUNK_BLOCKS);
      hint_lin   <= '0;
      hint_w     <= '0;
      hint_o     <= '0;
      rsp_valid  <= 1'b0;
      div_go     <= 1'b0;
      loaded_ok  <= 1'b0;
    end else begin
      div_go <= (accept && !bad_type && !bad_len && !no_room) ||
                ((state == S_DIV_S) && div_done);
      if ((state == S_RESP) && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(NUM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rtype      <= req.req_type;
            set_run    <= (req.req_type != REQ_FREE);
            n_lin      <= BW'(req.block_count);
            res_astart <= '0;
            loaded_ok  <= 1'b0;
            if (bad_type || bad_len) begin
              res_status <= ST_INVALID;
              state      <= S_RESP;
            end else if (no_room) begin
              res_status <= ST_NOSPACE;
              state      <= S_RESP;
            end else if (is_alloc) begin
              b_lin   <= LW'(hint_lin);
              b_w     <= hint_w;
              b_o     <= hint_o;
              div_arg <= BW'(req.block_count);
              state   <= S_DIV_N;
            end else begin
              b_lin   <= LW'(req.block_start);
              div_arg <= BW'(req.block_start);
              state   <= S_DIV_S;
            end
          end
        end
        S_DIV_S: begin
          if (div_done) begin
            b_w     <= WW'(div_quot);
            b_o     <= div_rem;
            div_arg <= n_lin;
            state   <= S_DIV_N;
          end
        end
        S_DIV_N: begin
          if (div_done) begin
            n_w   <= WW'(div_quot);
            n_o   <= div_rem;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          e_lin   <= e_lin_c;
          e_w     <= e_w_c;
          e_o     <= e_o_c;
          last_w  <= (e_o_c == '0) ? e_w_c - 1'b1 : e_w_c;
          last_hi <= (e_o_c == '0) ? OS'(WORD_BITS) : OS'(e_o_c);
          cur_w   <= b_w;
          if (e_lin_c > LW'(CHUNK_BLOCKS)) begin
            res_status <= ST_NOSPACE;
            state      <= S_RESP;
          end else if (loaded_ok && (loaded_w == b_w)) begin
            state <= S_CHK;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          loaded_w  <= cur_w;
          loaded_ok <= 1'b1;
          state     <= S_CHK;
        end
        S_CHK: begin
          if (!run_ok) begin
            if (rtype == REQ_ALLOC) begin
              b_lin <= e_lin;
              b_w   <= e_w;
              b_o   <= e_o;
              state <= S_SETUP;
            end else begin
              res_status <= ST_INVALID;
              state      <= S_RESP;
            end
          end else if (cur_w == last_w) begin
            cur_w <= b_w;
            state <= S_WR_RD;
          end else begin
            cur_w <= cur_w + 1'b1;
            state <= S_RD;
          end
        end
        S_WR_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (cur_w == last_w) begin
            state <= S_FIN;
          end else begin
            cur_w <= cur_w + 1'b1;
            state <= S_WR_RD;
          end
        end
        S_FIN: begin
          res_status <= ST_OK;
          if (set_run) begin
            free_count <= free_count - n_lin;
            hint_lin   <= BW'(e_lin);
            hint_w     <= e_w;
            hint_o     <= e_o;
            if (rtype == REQ_ALLOC) begin
              res_astart <= start_t'(b_lin);
            end
          end else begin
            free_count <= free_count + n_lin;
            if (b_lin < LW'(hint_lin)) begin
              hint_lin <= BW'(b_lin);
              hint_w   <= b_w;
              hint_o   <= b_o;
            end
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_status <= res_status;
            rsp_astart <= res_astart;
            rsp_free   <= free_t'(free_count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/bra_ram.sv]
module bra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/bra_div.sv]
module bra_div #(
  parameter int DW      = 13,
  parameter int DIVISOR = 64,
  parameter int RW      = $clog2(DIVISOR)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [RW-1:0] rem
);

  // split by a power-of-two divisor: shift for the quotient, mask for the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        quot <= dividend >> RW;
        rem  <= dividend[RW-1:0];
      end
    end
  end

endmodule

[rtl/core/bra_mask.sv]
module bra_mask #(
  parameter int WORD_BITS = 64,
  parameter int OW        = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] data,
  input  logic [OW-1:0]        lo,
  input  logic [OW:0]          hi,
  input  logic                 set_run,
  output logic                 run_ok,
  output logic [WORD_BITS-1:0] data_next
);

  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] hit;

  assign ones      = '1;
  assign mask      = (ones << lo) & ~(ones << hi);
  assign hit       = data & mask;
  assign run_ok    = set_run ? (hit == '0) : (hit == mask);
  assign data_next = set_run ? (data | mask) : (data & ~mask);

endmodule

[rtl/core/bra_chk.sv]
`include "bitmap_run_allocator_core_macros.svh"

module bra_chk
  import bra_pkg::*;
#(
  parameter int CHUNK_BLOCKS = CHUNK_BLOCKS_DEF
) (
  input logic    clk,
  input logic    rst,
  input logic    req_valid,
  input logic    req_ready,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input status_t status,
  input start_t  alloc_start,
  input free_t   free_blocks
);

  // hold a stalled result
  `BRA_ASSERT(a_rsp_hold, clk, rst,
              rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
              $stable(alloc_start) && $stable(free_blocks),
              "result changed while stalled")

  `BRA_ASSERT_ALWAYS(a_busy_after_reset, clk, rst |=> !req_ready, "ready during bitmap clear")

  `BRA_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready,
              "second item taken while busy")

  `BRA_ASSERT(a_start_only_ok, clk, rst, rsp_valid && (status != ST_OK) |-> alloc_start == '0,
              "start given on a failed request")

  `BRA_ASSERT(a_free_bound, clk, rst, rsp_valid |-> free_blocks <= CHUNK_BLOCKS,
              "free count above chunk size")

endmodule

bind bitmap_run_allocator_core bra_chk #(
  .CHUNK_BLOCKS (CHUNK_BLOCKS)
) u_bra_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .alloc_start (rsp.alloc_start),
  .free_blocks (rsp.free_blocks)
);
